>>> hdl/scp_pkg.sv
package scp_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int SQ_W    = 2 * MAG_W + 2;
    localparam int LEN_W   = SQ_W / 2 + 1;
    localparam int DEN_W   = LEN_W + 1;
    localparam int TGT_W   = 24;
    localparam int THR_W   = 16;
    localparam int CFG_W   = 24;
    localparam int QF      = 14;
    localparam int Q_W     = 16;
    localparam int TF_FB   = 2 * QF;
    localparam int TF_W    = TF_FB + 1;
    localparam int D2_W    = DEN_W + Q_W;
    localparam int QC_FB   = 2 * QF + 1;
    localparam int QC_W    = QC_FB + 1;

    localparam logic [Q_W-1:0]     Q_ONE   = Q_W'(1 << QF);
    localparam logic [COORD_W-1:0] LEN_MAX = '1;

    typedef enum logic [1:0] {
        CFG_TARGET0   = 2'd0,
        CFG_TARGET1   = 2'd1,
        CFG_THRESHOLD = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                      link;
        logic                      show;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic [SQ_W-1:0]           sq_sum;
    } t_front_item;

    typedef struct packed {
        logic                      link;
        logic                      show;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
    } t_side_a;

    typedef struct packed {
        logic                      link;
        logic                      show;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [COORD_W-1:0]        seg;
        logic [DEN_W-1:0]          den;
        logic                      zero;
    } t_side_b;

    typedef struct packed {
        logic                      link;
        logic                      show;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] mid_z;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [COORD_W-1:0]        seg;
        logic                      zero;
        logic                      wz;
        logic [Q_W-1:0]            w;
    } t_side_c;

    typedef struct packed {
        t_side_c c;
        logic    over_x;
    } t_side_d;

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] neg;
        neg = -v;
        return v[DIFF_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

>>> hdl/scp_fifo.sv
module scp_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/scp_front.sv
module scp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_link,
    input  logic signed [scp_pkg::COORD_W-1:0] i_a_x,
    input  logic signed [scp_pkg::COORD_W-1:0] i_a_y,
    input  logic signed [scp_pkg::COORD_W-1:0] i_a_z,
    input  logic signed [scp_pkg::COORD_W-1:0] i_b_x,
    input  logic signed [scp_pkg::COORD_W-1:0] i_b_y,
    input  logic signed [scp_pkg::COORD_W-1:0] i_b_z,
    input  logic [scp_pkg::TGT_W-1:0]          i_target0,
    input  logic [scp_pkg::TGT_W-1:0]          i_target1,
    input  logic [scp_pkg::THR_W-1:0]          i_threshold,
    output logic                               o_push,
    output scp_pkg::t_front_item               o_item,
    input  logic                               i_full
);

    localparam int CW = scp_pkg::COORD_W;
    localparam int DW = scp_pkg::DIFF_W;
    localparam int MW = scp_pkg::MAG_W;
    localparam int SW = scp_pkg::SQ_W;
    localparam int TW = scp_pkg::TGT_W;

    logic                 en;
    logic [TW-1:0]        tgt;
    logic [DW-1:0]        sum_x, sum_y, sum_z;

    logic                 r_s1_vld;
    logic                 r_s1_link;
    logic signed [CW-1:0] r_s1_mid_x, r_s1_mid_y, r_s1_mid_z;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy, r_s1_dz;
    logic [TW:0]          r_s1_hi;
    logic [TW-1:0]        r_s1_lo;
    logic                 r_s1_lo_ok;

    logic                 r_s2_vld;
    logic                 r_s2_link;
    logic signed [CW-1:0] r_s2_mid_x, r_s2_mid_y, r_s2_mid_z;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy, r_s2_dz;
    logic [2*MW-1:0]      r_s2_sx, r_s2_sy, r_s2_sz;
    logic [2*TW+1:0]      r_s2_hi2;
    logic [2*TW-1:0]      r_s2_lo2;
    logic                 r_s2_lo_ok;

    logic [SW-1:0]        sq_sum;

    assign en         = !r_s2_vld || !i_full;
    assign o_in_ready = en;
    assign o_push     = r_s2_vld && !i_full;

    assign tgt   = i_link ? i_target1 : i_target0;
    assign sum_x = DW'(i_a_x) + DW'(i_b_x);
    assign sum_y = DW'(i_a_y) + DW'(i_b_y);
    assign sum_z = DW'(i_a_z) + DW'(i_b_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_link  <= i_link;
            r_s1_mid_x <= sum_x[DW-1:1];
            r_s1_mid_y <= sum_y[DW-1:1];
            r_s1_mid_z <= sum_z[DW-1:1];
            r_s1_dx    <= DW'(i_b_x) - DW'(i_a_x);
            r_s1_dy    <= DW'(i_b_y) - DW'(i_a_y);
            r_s1_dz    <= DW'(i_b_z) - DW'(i_a_z);
            r_s1_hi    <= (TW + 1)'(tgt) + (TW + 1)'(i_threshold);
            r_s1_lo    <= tgt - TW'(i_threshold);
            r_s1_lo_ok <= tgt >= TW'(i_threshold);

            r_s2_link  <= r_s1_link;
            r_s2_mid_x <= r_s1_mid_x;
            r_s2_mid_y <= r_s1_mid_y;
            r_s2_mid_z <= r_s1_mid_z;
            r_s2_dx    <= r_s1_dx;
            r_s2_dy    <= r_s1_dy;
            r_s2_dz    <= r_s1_dz;
            r_s2_sx    <= scp_pkg::abs_diff(r_s1_dx) * scp_pkg::abs_diff(r_s1_dx);
            r_s2_sy    <= scp_pkg::abs_diff(r_s1_dy) * scp_pkg::abs_diff(r_s1_dy);
            r_s2_sz    <= scp_pkg::abs_diff(r_s1_dz) * scp_pkg::abs_diff(r_s1_dz);
            r_s2_hi2   <= r_s1_hi * r_s1_hi;
            r_s2_lo2   <= r_s1_lo * r_s1_lo;
            r_s2_lo_ok <= r_s1_lo_ok;
        end
    end

    assign sq_sum = SW'(r_s2_sx) + SW'(r_s2_sy) + SW'(r_s2_sz);

    always_comb begin
        o_item        = '0;
        o_item.link   = r_s2_link;
        o_item.show   = (sq_sum < SW'(r_s2_hi2)) && (!r_s2_lo_ok || (sq_sum > SW'(r_s2_lo2)));
        o_item.mid_x  = r_s2_mid_x;
        o_item.mid_y  = r_s2_mid_y;
        o_item.mid_z  = r_s2_mid_z;
        o_item.dx     = r_s2_dx;
        o_item.dy     = r_s2_dy;
        o_item.dz     = r_s2_dz;
        o_item.sq_sum = sq_sum;
    end

endmodule

>>> hdl/scp_isqrt.sv
module scp_isqrt #(
    parameter int VAL_W  = 50,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [VAL_W-1:0]   i_val,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [VAL_W/2:0]   o_root,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int RW = VAL_W / 2;

    logic              r_vld  [RW];
    logic [VAL_W-1:0]  r_val  [RW];
    logic [RW:0]       r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [SIDE_W-1:0] r_side [RW];

    logic              r_out_vld;
    logic [RW:0]       r_out_root;
    logic [SIDE_W-1:0] r_out_side;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              vld_c;
        logic [VAL_W-1:0]  val_c;
        logic [RW:0]       rem_c;
        logic [RW-1:0]     root_c;
        logic [SIDE_W-1:0] side_c;
        logic [RW+2:0]     cur;
        logic [RW+2:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign vld_c  = i_valid;
            assign val_c  = i_val;
            assign rem_c  = '0;
            assign root_c = '0;
            assign side_c = i_side;
        end else begin : g_next
            assign vld_c  = r_vld[k-1];
            assign val_c  = r_val[k-1];
            assign rem_c  = r_rem[k-1];
            assign root_c = r_root[k-1];
            assign side_c = r_side[k-1];
        end

        assign cur   = {rem_c, val_c[VAL_W-1 -: 2]};
        assign trial = {1'b0, root_c, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_c;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k]  <= {val_c[VAL_W-3:0], 2'b00};
                r_rem[k]  <= ge ? (RW + 1)'(cur - trial) : (RW + 1)'(cur);
                r_root[k] <= {root_c[RW-2:0], ge};
                r_side[k] <= side_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_root <= (RW + 1)'(r_root[RW-1])
                        + (RW + 1)'(r_rem[RW-1] > (RW + 1)'(r_root[RW-1]));
            r_out_side <= r_side[RW-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_root  = r_out_root;
    assign o_side  = r_out_side;

endmodule

>>> hdl/scp_fdiv.sv
module scp_fdiv #(
    parameter int DEN_W     = 27,
    parameter int FRAC_BITS = 28,
    parameter int SIDE_W    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DEN_W:0]       i_num,
    input  logic [DEN_W-1:0]     i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_quo,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int NS = FRAC_BITS + 1;

    logic               r_vld  [NS];
    logic [FRAC_BITS:0] r_quo  [NS];
    logic [DEN_W-1:0]   r_rem  [NS];
    logic [DEN_W-1:0]   r_den  [NS];
    logic [SIDE_W-1:0]  r_side [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic               vld_c;
        logic [DEN_W:0]     rem2;
        logic [DEN_W-1:0]   den_c;
        logic [FRAC_BITS:0] quo_c;
        logic [SIDE_W-1:0]  side_c;
        logic               ge;
        logic [DEN_W:0]     diff;

        if (k == 0) begin : g_first
            assign vld_c  = i_valid;
            assign rem2   = i_num;
            assign den_c  = i_den;
            assign quo_c  = '0;
            assign side_c = i_side;
        end else begin : g_next
            assign vld_c  = r_vld[k-1];
            assign rem2   = {r_rem[k-1], 1'b0};
            assign den_c  = r_den[k-1];
            assign quo_c  = r_quo[k-1];
            assign side_c = r_side[k-1];
        end

        assign ge   = rem2 >= {1'b0, den_c};
        assign diff = rem2 - {1'b0, den_c};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_c;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
                r_quo[k]  <= {quo_c[FRAC_BITS-1:0], ge};
                r_den[k]  <= den_c;
                r_side[k] <= side_c;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

>>> hdl/scp_back.sv
module scp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  scp_pkg::t_front_item               i_item,
    input  logic                               i_empty,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_link_out,
    output logic                               o_show,
    output logic signed [scp_pkg::COORD_W-1:0] o_mid_x,
    output logic signed [scp_pkg::COORD_W-1:0] o_mid_y,
    output logic signed [scp_pkg::COORD_W-1:0] o_mid_z,
    output logic [scp_pkg::COORD_W-1:0]        o_seg_length,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_w,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_x,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_y,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_z
);

    localparam int CW  = scp_pkg::COORD_W;
    localparam int LW  = scp_pkg::LEN_W;
    localparam int DNW = scp_pkg::DEN_W;
    localparam int QW  = scp_pkg::Q_W;
    localparam int D2W = scp_pkg::D2_W;
    localparam int QCW = scp_pkg::QC_W;
    localparam int SAW = $bits(scp_pkg::t_side_a);
    localparam int SBW = $bits(scp_pkg::t_side_b);
    localparam int SDW = $bits(scp_pkg::t_side_d);

    logic en;

    // length root
    scp_pkg::t_side_a sa_in;
    scp_pkg::t_side_a sa;
    logic [SAW-1:0]   sa_bits;
    logic             sa_vld;
    logic [LW-1:0]    lr;

    // length, clamp and cosine numerator
    logic                      zero;
    logic [DNW-1:0]            den;
    logic signed [DNW:0]       n_raw;
    logic [DNW-1:0]            n_clamp;
    logic [CW-1:0]             seg;
    logic                      r_b_vld;
    scp_pkg::t_side_b          r_b_side;
    logic [DNW:0]              r_b_num;
    logic [DNW-1:0]            r_b_den;

    logic                      tf_vld;
    logic [scp_pkg::TF_W-1:0]  tf;
    logic [SBW-1:0]            tf_side;

    logic                      w_vld;
    logic [QW-1:0]             w;
    logic [SBW-1:0]            w_side_bits;
    scp_pkg::t_side_b          w_side;

    logic                      r_c_vld;
    scp_pkg::t_side_c          r_c_side;
    logic [D2W-1:0]            r_c_d2;

    logic                      deg;
    logic [scp_pkg::MAG_W-1:0] mag_x, mag_y;
    logic                      over_x, over_y;
    logic [D2W-1:0]            den_q;
    scp_pkg::t_side_d          sd_in;

    logic                      qd_vld;
    logic [QCW-1:0]            quo_x, quo_y;
    logic [SDW-1:0]            sd_bits;
    scp_pkg::t_side_d          sd;
    logic                      over_y_d;

    logic [QCW:0]              rnd_x, rnd_y;
    logic [QW-1:0]             mag_qx, mag_qy;
    logic [QW-1:0]             qx, qy;

    logic                      r_o_valid;
    logic                      r_o_link;
    logic                      r_o_show;
    logic signed [CW-1:0]      r_o_mid_x, r_o_mid_y, r_o_mid_z;
    logic [CW-1:0]             r_o_seg;
    logic [QW-1:0]             r_o_qw, r_o_qx, r_o_qy;

    assign en    = !r_o_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        sa_in.link  = i_item.link;
        sa_in.show  = i_item.show;
        sa_in.mid_x = i_item.mid_x;
        sa_in.mid_y = i_item.mid_y;
        sa_in.mid_z = i_item.mid_z;
        sa_in.dx    = i_item.dx;
        sa_in.dy    = i_item.dy;
        sa_in.dz    = i_item.dz;
    end

    scp_isqrt #(
        .VAL_W  (scp_pkg::SQ_W),
        .SIDE_W (SAW)
    ) u_len_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (!i_empty),
        .i_val   (i_item.sq_sum),
        .i_side  (sa_in),
        .o_valid (sa_vld),
        .o_root  (lr),
        .o_side  (sa_bits)
    );

    assign sa    = sa_bits;
    assign zero  = (lr == '0);
    assign den   = {lr, 1'b0};
    assign n_raw = (DNW + 1)'({1'b0, lr}) + (DNW + 1)'(sa.dz);

    always_comb begin
        if (n_raw[DNW]) begin
            n_clamp = '0;
        end else if (n_raw[DNW-1:0] > den) begin
            n_clamp = den;
        end else begin
            n_clamp = n_raw[DNW-1:0];
        end
        if (zero) begin
            seg = CW'(1);
        end else if (lr > LW'(scp_pkg::LEN_MAX)) begin
            seg = scp_pkg::LEN_MAX;
        end else begin
            seg = lr[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= sa_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side.link  <= sa.link;
            r_b_side.show  <= sa.show;
            r_b_side.mid_x <= sa.mid_x;
            r_b_side.mid_y <= sa.mid_y;
            r_b_side.mid_z <= sa.mid_z;
            r_b_side.dx    <= sa.dx;
            r_b_side.dy    <= sa.dy;
            r_b_side.seg   <= seg;
            r_b_side.den   <= den;
            r_b_side.zero  <= zero;
            r_b_num        <= zero ? '0 : {1'b0, n_clamp};
            r_b_den        <= zero ? DNW'(1) : den;
        end
    end

    scp_fdiv #(
        .DEN_W     (DNW),
        .FRAC_BITS (scp_pkg::TF_FB),
        .SIDE_W    (SBW)
    ) u_cos_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_vld),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .i_side  (r_b_side),
        .o_valid (tf_vld),
        .o_quo   (tf),
        .o_side  (tf_side)
    );

    scp_isqrt #(
        .VAL_W  (scp_pkg::TF_W + 1),
        .SIDE_W (SBW)
    ) u_w_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (tf_vld),
        .i_val   ({1'b0, tf}),
        .i_side  (tf_side),
        .o_valid (w_vld),
        .o_root  (w),
        .o_side  (w_side_bits)
    );

    assign w_side = w_side_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side.link  <= w_side.link;
            r_c_side.show  <= w_side.show;
            r_c_side.mid_x <= w_side.mid_x;
            r_c_side.mid_y <= w_side.mid_y;
            r_c_side.mid_z <= w_side.mid_z;
            r_c_side.dx    <= w_side.dx;
            r_c_side.dy    <= w_side.dy;
            r_c_side.seg   <= w_side.seg;
            r_c_side.zero  <= w_side.zero;
            r_c_side.wz    <= (w == '0);
            r_c_side.w     <= w;
            r_c_d2         <= w_side.den * w;
        end
    end

    assign deg    = r_c_side.zero || r_c_side.wz;
    assign mag_x  = scp_pkg::abs_diff(r_c_side.dx);
    assign mag_y  = scp_pkg::abs_diff(r_c_side.dy);
    assign over_x = (D2W + 1)'(mag_x) >= {r_c_d2, 1'b0};
    assign over_y = (D2W + 1)'(mag_y) >= {r_c_d2, 1'b0};
    assign den_q  = deg ? D2W'(1) : r_c_d2;

    always_comb begin
        sd_in.c      = r_c_side;
        sd_in.over_x = over_x;
    end

    scp_fdiv #(
        .DEN_W     (D2W),
        .FRAC_BITS (scp_pkg::QC_FB),
        .SIDE_W    (SDW)
    ) u_qy_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_num   ((deg || over_x) ? '0 : (D2W + 1)'(mag_x)),
        .i_den   (den_q),
        .i_side  (sd_in),
        .o_valid (qd_vld),
        .o_quo   (quo_x),
        .o_side  (sd_bits)
    );

    scp_fdiv #(
        .DEN_W     (D2W),
        .FRAC_BITS (scp_pkg::QC_FB),
        .SIDE_W    (1)
    ) u_qx_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_num   ((deg || over_y) ? '0 : (D2W + 1)'(mag_y)),
        .i_den   (den_q),
        .i_side  (over_y),
        .o_valid (),
        .o_quo   (quo_y),
        .o_side  (over_y_d)
    );

    assign sd    = sd_bits;
    assign rnd_x = ((QCW + 1)'(quo_x) + (QCW + 1)'(1)) >> 1;
    assign rnd_y = ((QCW + 1)'(quo_y) + (QCW + 1)'(1)) >> 1;

    always_comb begin
        if (sd.over_x || rnd_x > (QCW + 1)'(scp_pkg::Q_ONE)) begin
            mag_qy = scp_pkg::Q_ONE;
        end else begin
            mag_qy = rnd_x[QW-1:0];
        end
        if (over_y_d || rnd_y > (QCW + 1)'(scp_pkg::Q_ONE)) begin
            mag_qx = scp_pkg::Q_ONE;
        end else begin
            mag_qx = rnd_y[QW-1:0];
        end
        qy = sd.c.dx[scp_pkg::DIFF_W-1] ? -mag_qy : mag_qy;
        qx = sd.c.dy[scp_pkg::DIFF_W-1] ? mag_qx : -mag_qx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= qd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_link  <= sd.c.link;
            r_o_show  <= sd.c.show;
            r_o_mid_x <= sd.c.mid_x;
            r_o_mid_y <= sd.c.mid_y;
            r_o_mid_z <= sd.c.mid_z;
            r_o_seg   <= sd.c.seg;
            if (sd.c.zero) begin
                r_o_qw <= scp_pkg::Q_ONE;
                r_o_qx <= '0;
                r_o_qy <= '0;
            end else if (sd.c.wz) begin
                r_o_qw <= '0;
                r_o_qx <= scp_pkg::Q_ONE;
                r_o_qy <= '0;
            end else begin
                r_o_qw <= sd.c.w;
                r_o_qx <= qx;
                r_o_qy <= qy;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_link_out   = r_o_link;
    assign o_show       = r_o_show;
    assign o_mid_x      = r_o_mid_x;
    assign o_mid_y      = r_o_mid_y;
    assign o_mid_z      = r_o_mid_z;
    assign o_seg_length = r_o_seg;
    assign o_quat_w     = r_o_qw;
    assign o_quat_x     = r_o_qx;
    assign o_quat_y     = r_o_qy;
    assign o_quat_z     = '0;

endmodule

>>> hdl/segment_cylinder_pose.sv
// Link pose for cylinder drawing: each transaction carries two endpoints and a
// link index; the result gives the floor midpoint, the rounded length, a show
// flag (length strictly within the hide threshold of the link's target) and the
// Q2.14 quaternion turning +Z onto the link. One transaction is accepted and one
// delivered per cycle when the output is taken. A transaction passes the front
// stages (difference, then squares and window compare), the queue, and the back
// pipeline of bit-serial stages: the length root, the cosine divide, the w root
// and the x/y divides. A held output stalls the back pipeline as a whole; the
// queue absorbs the front's work until it fills.
module segment_cylinder_pose #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_link_index,
    input  logic signed [scp_pkg::COORD_W-1:0] i_end_a_x,
    input  logic signed [scp_pkg::COORD_W-1:0] i_end_a_y,
    input  logic signed [scp_pkg::COORD_W-1:0] i_end_a_z,
    input  logic signed [scp_pkg::COORD_W-1:0] i_end_b_x,
    input  logic signed [scp_pkg::COORD_W-1:0] i_end_b_y,
    input  logic signed [scp_pkg::COORD_W-1:0] i_end_b_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_link_out,
    output logic                               o_show,
    output logic signed [scp_pkg::COORD_W-1:0] o_mid_x,
    output logic signed [scp_pkg::COORD_W-1:0] o_mid_y,
    output logic signed [scp_pkg::COORD_W-1:0] o_mid_z,
    output logic [scp_pkg::COORD_W-1:0]        o_seg_length,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_w,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_x,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_y,
    output logic signed [scp_pkg::Q_W-1:0]     o_quat_z
);

    localparam int ITEM_W = $bits(scp_pkg::t_front_item);

    logic [scp_pkg::TGT_W-1:0] r_target0;
    logic [scp_pkg::TGT_W-1:0] r_target1;
    logic [scp_pkg::THR_W-1:0] r_threshold;

    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 empty;
    scp_pkg::t_front_item front_item;
    logic [ITEM_W-1:0]    head_bits;
    scp_pkg::t_front_item head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target0   <= scp_pkg::TGT_W'(169500);
            r_target1   <= scp_pkg::TGT_W'(81000);
            r_threshold <= scp_pkg::THR_W'(2000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scp_pkg::CFG_TARGET0:   r_target0   <= i_cfg_data[scp_pkg::TGT_W-1:0];
                scp_pkg::CFG_TARGET1:   r_target1   <= i_cfg_data[scp_pkg::TGT_W-1:0];
                scp_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[scp_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    scp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_link      (i_link_index),
        .i_a_x       (i_end_a_x),
        .i_a_y       (i_end_a_y),
        .i_a_z       (i_end_a_z),
        .i_b_x       (i_end_b_x),
        .i_b_y       (i_end_b_y),
        .i_b_z       (i_end_b_z),
        .i_target0   (r_target0),
        .i_target1   (r_target1),
        .i_threshold (r_threshold),
        .o_push      (push),
        .o_item      (front_item),
        .i_full      (full)
    );

    scp_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_empty (empty)
    );

    assign head_item = head_bits;

    scp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_link_out   (o_link_out),
        .o_show       (o_show),
        .o_mid_x      (o_mid_x),
        .o_mid_y      (o_mid_y),
        .o_mid_z      (o_mid_z),
        .o_seg_length (o_seg_length),
        .o_quat_w     (o_quat_w),
        .o_quat_x     (o_quat_x),
        .o_quat_y     (o_quat_y),
        .o_quat_z     (o_quat_z)
    );

endmodule
